@@ hdl/vaf_pkg.sv @@
// ----------------------------------------------------------------------------
// vaf_pkg - shared types and constants for the fixed-point vector ALU
// Field layout of the stream words, operation and status codes, the sideband
// record that rides along the root and divide pipes, and the 32-bit clamp.
// ----------------------------------------------------------------------------
package vaf_pkg;

  localparam int W             = 32;   // component width
  localparam int N_COMP        = 4;    // components per vector
  localparam int FRAC_BITS_DEF = 16;

  localparam int PROD_W   = 2 * W;     // full product
  localparam int SUM_W    = W + 1;     // add/sub of two components
  localparam int SQSUM_W  = PROD_W + 1;
  localparam int RAD_W    = PROD_W + 2; // sum of four squares, even width
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SAT_IN_W = RAD_W;

  // stream word layout
  localparam int IN_TUSER_W  = 3;
  localparam int IN_DIM_LSB  = 0;
  localparam int IN_A_LSB    = 3;
  localparam int IN_B_LSB    = IN_A_LSB + N_COMP * W;
  localparam int IN_F_LSB    = IN_B_LSB + N_COMP * W;
  localparam int IN_TDATA_W  = ((IN_F_LSB + W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = (N_COMP + 1) * W;
  localparam int OUT_TUSER_W = 2;

  localparam logic [2:0] DIM_2 = 3'd2;
  localparam logic [2:0] DIM_3 = 3'd3;
  localparam logic [2:0] DIM_4 = 3'd4;

  typedef enum logic [2:0] {
    F_DOT   = 3'd0,
    F_CROSS = 3'd1,
    F_ADD   = 3'd2,
    F_SUB   = 3'd3,
    F_SCALE = 3'd4,
    F_LEN   = 3'd5,
    F_NORM  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_XDIM = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // result record carried past the root and divide pipes
  typedef struct packed {
    logic [N_COMP-1:0][W-1:0] r;
    logic [W-1:0]             scalar;
    status_e                  status;
    logic                     is_len;
    logic                     is_norm;
  } side_t;

  typedef struct packed {
    logic         ovf;
    logic [W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] v);
    sat_t s;
    logic fits;
    fits  = (v[SAT_IN_W-1:W-1] == '0) || (v[SAT_IN_W-1:W-1] == '1);
    s.ovf = !fits;
    if (fits) begin
      s.val = v[W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      s.val = {1'b1, {(W-1){1'b0}}};
    end else begin
      s.val = {1'b0, {(W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

@@ hdl/vector_alu_fixed_point_top.sv @@
// ----------------------------------------------------------------------------
// vector_alu_fixed_point_top - fixed-point vector ALU
// Dot, cross, add, sub, scale, length and normalize on 2..4 component
// Q-format vectors, saturating to 32 bits, one op per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   | dir | signals                     | contents
//  ----------+-----+-----------------------------+------------------------------
//  s_axis    | in  | tvalid tready tdata tuser   | operands; tuser = operation
//  m_axis    | out | tvalid tready tdata tuser   | results; tuser = status
//
//  Every operation passes through four arithmetic stages, a 33-stage
//  square root (one root bit per stage) and a FRAC_BITS+1 stage divider
//  (one quotient bit per stage, FRAC_BITS = 16 at Q16.16), plus the output
//  register. One transfer per cycle in and out unless stalled: a result
//  held at the output while m_axis_tready is low freezes the whole pipe;
//  nothing is lost or repeated. Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
module vector_alu_fixed_point_top #(
  parameter int FRAC_BITS = vaf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // dim[2:0], a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor, zero pad
  input  logic [vaf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func[2:0]
  input  logic [vaf_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // r_x, r_y, r_z, r_w, scalar_out
  output logic [vaf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [vaf_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  localparam int W       = vaf_pkg::W;
  localparam int NC      = vaf_pkg::N_COMP;
  localparam int PW      = vaf_pkg::PROD_W;
  localparam int SUMW    = vaf_pkg::SUM_W;
  localparam int SQW     = vaf_pkg::SQSUM_W;
  localparam int RADW    = vaf_pkg::RAD_W;
  localparam int QW      = vaf_pkg::ROOT_W;
  localparam int SW      = vaf_pkg::SAT_IN_W;
  localparam int DIV_LAT = FRAC_BITS + 1;

  logic en;

  // input decode
  logic [2:0]           dim_in;
  logic [2:0]           n_in;
  logic signed [W-1:0]  a_in [NC];
  logic signed [W-1:0]  b_in [NC];

  // stage A
  logic                 vld_a;
  vaf_pkg::func_e       func_a;
  logic signed [W-1:0]  a_a [NC];
  logic signed [W-1:0]  b_a [NC];
  logic signed [W-1:0]  f_a;
  logic [2:0]           n_a;

  // stage B
  logic signed [W-1:0]  pa [NC];
  logic signed [W-1:0]  pb [NC];
  logic                 vld_b;
  vaf_pkg::func_e       func_b;
  logic [2:0]           n_b;
  logic signed [W-1:0]  a_b [NC];
  logic signed [PW-1:0] p_b [NC];
  logic signed [PW-1:0] q_b [3];
  logic signed [SUMW-1:0] s_b [NC];

  // stage C
  logic signed [PW-1:0] sh_p [NC];
  logic signed [PW-1:0] sh_q [3];
  logic                 vld_c;
  vaf_pkg::func_e       func_c;
  logic [2:0]           n_c;
  logic signed [W-1:0]  a_c [NC];
  logic signed [PW-1:0] d_c [2];
  logic [SQW-1:0]       sq_c [2];
  logic signed [PW-1:0] cr_c [3];
  logic signed [PW-1:0] sc_c [NC];
  logic signed [SUMW-1:0] as_c [NC];

  // stage D
  vaf_pkg::sat_t        sat_dot;
  vaf_pkg::sat_t        sat_cr [3];
  vaf_pkg::sat_t        sat_sc [NC];
  vaf_pkg::sat_t        sat_as [NC];
  vaf_pkg::side_t       side_nx;
  logic                 ovf_nx;
  logic [RADW-1:0]      rad_nx;
  logic                 vld_d;
  vaf_pkg::side_t       side_d;
  logic [RADW-1:0]      rad_d;

  // root and divide pipes
  logic [QW-1:0]        root_sq;
  logic                 vld_sq  [QW];
  vaf_pkg::side_t       side_sq [QW];
  logic [W-1:0]         mag     [NC];
  logic [FRAC_BITS:0]   quo     [NC];
  logic                 vld_dv  [DIV_LAT];
  vaf_pkg::side_t       side_dv [DIV_LAT];
  logic [QW-1:0]        root_dv [DIV_LAT];

  // output stage
  vaf_pkg::side_t       fin;
  logic [QW-1:0]        fin_root;
  logic [NC-1:0][W-1:0] out_r;
  logic [W-1:0]         out_scalar;
  vaf_pkg::status_e     out_status;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- input decode: clamp dim, zero unused components -------
  always_comb begin
    dim_in = s_axis_tdata[vaf_pkg::IN_DIM_LSB +: 3];
    if (dim_in < vaf_pkg::DIM_2) begin
      n_in = vaf_pkg::DIM_2;
    end else if (dim_in > vaf_pkg::DIM_4) begin
      n_in = vaf_pkg::DIM_4;
    end else begin
      n_in = dim_in;
    end
    for (int i = 0; i < NC; i++) begin
      if (3'(i) < n_in) begin
        a_in[i] = s_axis_tdata[vaf_pkg::IN_A_LSB + W * i +: W];
        b_in[i] = s_axis_tdata[vaf_pkg::IN_B_LSB + W * i +: W];
      end else begin
        a_in[i] = '0;
        b_in[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_a <= vaf_pkg::func_e'(s_axis_tuser);
      n_a    <= n_in;
      f_a    <= s_axis_tdata[vaf_pkg::IN_F_LSB +: W];
      for (int i = 0; i < NC; i++) begin
        a_a[i] <= a_in[i];
        b_a[i] <= b_in[i];
      end
    end
  end

  // ---------------- stage B: multiply and add/sub ------------------------
  always_comb begin
    case (func_a) inside
      vaf_pkg::F_CROSS: begin
        pa = '{a_a[1], a_a[2], a_a[0], 32'sd0};
        pb = '{b_a[2], b_a[0], b_a[1], 32'sd0};
      end
      vaf_pkg::F_SCALE: begin
        pa = a_a;
        pb = '{f_a, f_a, f_a, f_a};
      end
      vaf_pkg::F_LEN, vaf_pkg::F_NORM: begin
        pa = a_a;
        pb = a_a;
      end
      default: begin
        pa = a_a;
        pb = b_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_b <= func_a;
      n_b    <= n_a;
      for (int i = 0; i < NC; i++) begin
        a_b[i] <= a_a[i];
        p_b[i] <= PW'(pa[i]) * PW'(pb[i]);
        s_b[i] <= (func_a == vaf_pkg::F_SUB) ? SUMW'(a_a[i]) - SUMW'(b_a[i])
                                             : SUMW'(a_a[i]) + SUMW'(b_a[i]);
      end
      // cross partners: x = a1b2 - a2b1, y = a2b0 - a0b2, z = a0b1 - a1b0
      q_b[0] <= PW'(a_a[2]) * PW'(b_a[1]);
      q_b[1] <= PW'(a_a[0]) * PW'(b_a[2]);
      q_b[2] <= PW'(a_a[1]) * PW'(b_a[0]);
    end
  end

  // ---------------- stage C: rescale, pair sums, differences -------------
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sh_p[i] = p_b[i] >>> FRAC_BITS;
    end
    for (int j = 0; j < 3; j++) begin
      sh_q[j] = q_b[j] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_c  <= func_b;
      n_c     <= n_b;
      d_c[0]  <= sh_p[0] + sh_p[1];
      d_c[1]  <= sh_p[2] + sh_p[3];
      sq_c[0] <= {1'b0, p_b[0]} + {1'b0, p_b[1]};
      sq_c[1] <= {1'b0, p_b[2]} + {1'b0, p_b[3]};
      for (int j = 0; j < 3; j++) begin
        cr_c[j] <= sh_p[j] - sh_q[j];
      end
      for (int i = 0; i < NC; i++) begin
        a_c[i]  <= a_b[i];
        sc_c[i] <= sh_p[i];
        as_c[i] <= s_b[i];
      end
    end
  end

  // ---------------- stage D: final sums, clamp, select -------------------
  always_comb begin
    sat_dot = vaf_pkg::sat32(SW'(d_c[0] + d_c[1]));
    for (int j = 0; j < 3; j++) begin
      sat_cr[j] = vaf_pkg::sat32(SW'(cr_c[j]));
    end
    for (int i = 0; i < NC; i++) begin
      sat_sc[i] = vaf_pkg::sat32(SW'(sc_c[i]));
      sat_as[i] = vaf_pkg::sat32(SW'(as_c[i]));
    end
  end

  always_comb begin
    side_nx        = '0;
    side_nx.status = vaf_pkg::ST_OK;
    ovf_nx         = 1'b0;
    rad_nx         = '0;
    unique case (func_c)
      vaf_pkg::F_DOT: begin
        side_nx.scalar = sat_dot.val;
        ovf_nx         = sat_dot.ovf;
      end
      vaf_pkg::F_CROSS: begin
        if (n_c == vaf_pkg::DIM_2) begin
          side_nx.scalar = sat_cr[2].val;
          ovf_nx         = sat_cr[2].ovf;
        end else if (n_c == vaf_pkg::DIM_3) begin
          for (int j = 0; j < 3; j++) begin
            side_nx.r[j] = sat_cr[j].val;
            ovf_nx       = ovf_nx | sat_cr[j].ovf;
          end
        end else begin
          side_nx.status = vaf_pkg::ST_XDIM;
        end
      end
      vaf_pkg::F_ADD, vaf_pkg::F_SUB: begin
        for (int i = 0; i < NC; i++) begin
          side_nx.r[i] = sat_as[i].val;
          ovf_nx       = ovf_nx | sat_as[i].ovf;
        end
      end
      vaf_pkg::F_SCALE: begin
        for (int i = 0; i < NC; i++) begin
          side_nx.r[i] = sat_sc[i].val;
          ovf_nx       = ovf_nx | sat_sc[i].ovf;
        end
      end
      vaf_pkg::F_LEN: begin
        side_nx.is_len = 1'b1;
        rad_nx         = {1'b0, sq_c[0]} + {1'b0, sq_c[1]};
      end
      vaf_pkg::F_NORM: begin
        // hold the source vector; it is the answer when the length is zero
        side_nx.is_norm = 1'b1;
        rad_nx          = {1'b0, sq_c[0]} + {1'b0, sq_c[1]};
        for (int i = 0; i < NC; i++) begin
          side_nx.r[i] = a_c[i];
        end
      end
      default: begin
      end
    endcase
    if (ovf_nx && side_nx.status == vaf_pkg::ST_OK) begin
      side_nx.status = vaf_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d <= side_nx;
      rad_d  <= rad_nx;
    end
  end

  // ---------------- square root pipe -------------------------------------
  vaf_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_d),
    .root (root_sq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq[0] <= side_d;
      for (int k = 1; k < QW; k++) begin
        side_sq[k] <= side_sq[k-1];
      end
    end
  end

  // ---------------- divide lanes -----------------------------------------
  for (genvar i = 0; i < NC; i++) begin : g_lane
    assign mag[i] = side_sq[QW-1].r[i][W-1] ? ~side_sq[QW-1].r[i] + W'(1)
                                            : side_sq[QW-1].r[i];
    vaf_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .mag (mag[i]),
      .den (root_sq),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dv[0] <= side_sq[QW-1];
      root_dv[0] <= root_sq;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_dv[k] <= side_dv[k-1];
        root_dv[k] <= root_dv[k-1];
      end
    end
  end

  // ---------------- output stage -----------------------------------------
  always_comb begin
    fin        = side_dv[DIV_LAT-1];
    fin_root   = root_dv[DIV_LAT-1];
    out_r      = fin.r;
    out_scalar = fin.scalar;
    out_status = fin.status;
    if (fin.is_len) begin
      if (fin_root[QW-1:W-1] != '0) begin
        out_scalar = {1'b0, {(W-1){1'b1}}};
        out_status = vaf_pkg::ST_SAT;
      end else begin
        out_scalar = fin_root[W-1:0];
      end
    end
    if (fin.is_norm && fin_root != '0) begin
      for (int i = 0; i < NC; i++) begin
        out_r[i] = fin.r[i][W-1] ? -W'(quo[i]) : W'(quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {out_scalar, out_r[3], out_r[2], out_r[1], out_r[0]};
      m_axis_tuser <= out_status;
    end
  end

  // ---------------- valid bits -------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a         <= 1'b0;
      vld_b         <= 1'b0;
      vld_c         <= 1'b0;
      vld_d         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < QW; k++) begin
        vld_sq[k] <= 1'b0;
      end
      for (int k = 0; k < DIV_LAT; k++) begin
        vld_dv[k] <= 1'b0;
      end
    end else if (en) begin
      vld_a     <= s_axis_tvalid;
      vld_b     <= vld_a;
      vld_c     <= vld_b;
      vld_d     <= vld_c;
      vld_sq[0] <= vld_d;
      for (int k = 1; k < QW; k++) begin
        vld_sq[k] <= vld_sq[k-1];
      end
      vld_dv[0] <= vld_sq[QW-1];
      for (int k = 1; k < DIV_LAT; k++) begin
        vld_dv[k] <= vld_dv[k-1];
      end
      m_axis_tvalid <= vld_dv[DIV_LAT-1];
    end
  end

endmodule

@@ hdl/vaf_isqrt.sv @@
// ----------------------------------------------------------------------------
// vaf_isqrt - pipelined integer square root
// One root bit per stage over ROOT_W stages; floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module vaf_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vaf_pkg::RAD_W-1:0]   rad,
  output logic [vaf_pkg::ROOT_W-1:0]  root
);

  localparam int RW = vaf_pkg::RAD_W;
  localparam int QW = vaf_pkg::ROOT_W;

  logic [RW-1:0] v   [QW];
  logic [RW-1:0] res [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam logic [RW-1:0] ONE = RW'(1) << (2 * (QW - 1 - k));
    logic [RW-1:0] v_in;
    logic [RW-1:0] r_in;
    logic [RW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in = rad;
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = v[k-1];
      assign r_in = res[k-1];
    end

    assign trial = r_in + ONE;
    assign take  = v_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        v[k]   <= take ? v_in - trial : v_in;
        res[k] <= take ? (r_in >> 1) + ONE : r_in >> 1;
      end
    end
  end

  assign root = res[QW-1][QW-1:0];

endmodule

@@ hdl/vaf_div.sv @@
// ----------------------------------------------------------------------------
// vaf_div - pipelined restoring divider for normalize
// quo = (mag << FRAC_BITS) / den, one quotient bit per stage. Expects
// mag <= den, so the quotient fits in FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module vaf_div #(
  parameter int FRAC_BITS = vaf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vaf_pkg::W-1:0]       mag,
  input  logic [vaf_pkg::ROOT_W-1:0]  den,
  output logic [FRAC_BITS:0]          quo
);

  localparam int STEPS = FRAC_BITS + 1;
  localparam int DW    = vaf_pkg::ROOT_W;
  localparam int RW    = DW + 1;

  logic [RW-1:0]    rem [STEPS];
  logic [DW-1:0]    dv  [STEPS];
  logic [STEPS-1:0] q   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RW-1:0]    r_sh;
    logic [DW-1:0]    d_in;
    logic [STEPS-1:0] q_in;
    logic             qbit;

    if (k == 0) begin : g_first
      assign r_sh = RW'(mag);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_sh = rem[k-1] << 1;
      assign d_in = dv[k-1];
      assign q_in = q[k-1];
    end

    assign qbit = r_sh >= RW'(d_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= qbit ? r_sh - RW'(d_in) : r_sh;
        dv[k]  <= d_in;
        q[k]   <= {q_in[STEPS-2:0], qbit};
      end
    end
  end

  assign quo = q[STEPS-1];

endmodule

@@ hdl/vaf_checker.sv @@
// ----------------------------------------------------------------------------
// vaf_checker - port-level checks for the fixed-point vector ALU
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module vaf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [vaf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [vaf_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  localparam logic [vaf_pkg::W-1:0] MAXV = {1'b0, {(vaf_pkg::W-1){1'b1}}};
  localparam logic [vaf_pkg::W-1:0] MINV = {1'b1, {(vaf_pkg::W-1){1'b0}}};

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // cross at dimension four carries all-zero values
  a_xdim: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == vaf_pkg::ST_XDIM |-> m_axis_tdata == '0)
    else $error("nonzero values with dimension error");

  // a saturated result shows at least one clamped value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == vaf_pkg::ST_SAT |->
      m_axis_tdata[31:0] == MAXV || m_axis_tdata[31:0] == MINV ||
      m_axis_tdata[63:32] == MAXV || m_axis_tdata[63:32] == MINV ||
      m_axis_tdata[95:64] == MAXV || m_axis_tdata[95:64] == MINV ||
      m_axis_tdata[127:96] == MAXV || m_axis_tdata[127:96] == MINV ||
      m_axis_tdata[159:128] == MAXV || m_axis_tdata[159:128] == MINV)
    else $error("saturated status without a clamped value");

endmodule

bind vector_alu_fixed_point_top vaf_checker u_vaf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb_vector_alu_fixed_point_top.sv @@
// ----------------------------------------------------------------------------
// tb_vector_alu_fixed_point_top - self-checking bench for the vector ALU
// Drives a directed table of operand sets and then random operations through
// the input stream. A local predictor works out each result that the table
// does not type in, and the output stream is compared field by field in order,
// under random idling on both sides but for the last third of the random run.
// ----------------------------------------------------------------------------
module tb_vector_alu_fixed_point_top;

  localparam int FB        = 16;
  localparam int LATENCY   = 39 + FB;
  localparam int N_RANDOM  = 1130;
  localparam int MAX_CYCLE = 400000;

  typedef struct {
    logic [2:0]       func;
    logic [2:0]       dim;
    logic signed [31:0] a [4];
    logic signed [31:0] b [4];
    logic signed [31:0] factor;
  } vec_op_t;

  typedef struct {
    logic [31:0] r [4];
    logic [31:0] scalar;
    logic [1:0]  status;
  } vec_res_t;

  typedef struct {
    vec_op_t  op;
    bit       has_exp;
    vec_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [vaf_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [vaf_pkg::IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [vaf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [vaf_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  vec_res_t expected_q [$];
  int mismatches = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 87;
  longint cycles = 0;

  vector_alu_fixed_point_top #(.FRAC_BITS(FB)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [65:0] floor_mul(logic signed [31:0] x,
                                                   logic signed [31:0] y);
    logic signed [65:0] p;
    p = 66'(x) * 66'(y);
    return p >>> FB;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [67:0] v, ref bit sat);
    if (v > 68'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -68'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [66:0] root_floor(logic [66:0] v);
    logic [66:0] res, bitv;
    res = '0;
    bitv = 67'd1 << 66;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vec_res_t predict_vec_op(vec_op_t op);
    vec_res_t o;
    bit sat;
    int n;
    logic signed [67:0] acc;
    logic [66:0] sq_sum, len;
    logic [98:0] mag;
    logic signed [67:0] q;
    sat = 1'b0;
    n = op.dim < 2 ? 2 : (op.dim > 4 ? 4 : int'(op.dim));
    for (int i = 0; i < 4; i++) o.r[i] = '0;
    o.scalar = '0;
    o.status = vaf_pkg::ST_OK;
    case (op.func)
      vaf_pkg::F_DOT: begin
        acc = 0;
        for (int i = 0; i < n; i++) acc += floor_mul(op.a[i], op.b[i]);
        o.scalar = clamp32(acc, sat);
      end
      vaf_pkg::F_CROSS: begin
        if (n == 2) begin
          o.scalar = clamp32(floor_mul(op.a[0], op.b[1]) - floor_mul(op.a[1], op.b[0]), sat);
        end else if (n == 3) begin
          o.r[0] = clamp32(floor_mul(op.a[1], op.b[2]) - floor_mul(op.a[2], op.b[1]), sat);
          o.r[1] = clamp32(floor_mul(op.a[2], op.b[0]) - floor_mul(op.a[0], op.b[2]), sat);
          o.r[2] = clamp32(floor_mul(op.a[0], op.b[1]) - floor_mul(op.a[1], op.b[0]), sat);
        end else begin
          o.status = vaf_pkg::ST_XDIM;
        end
      end
      vaf_pkg::F_ADD:
        for (int i = 0; i < n; i++) o.r[i] = clamp32(68'(op.a[i]) + op.b[i], sat);
      vaf_pkg::F_SUB:
        for (int i = 0; i < n; i++) o.r[i] = clamp32(68'(op.a[i]) - op.b[i], sat);
      vaf_pkg::F_SCALE:
        for (int i = 0; i < n; i++) o.r[i] = clamp32(floor_mul(op.a[i], op.factor), sat);
      vaf_pkg::F_LEN, vaf_pkg::F_NORM: begin
        // sum of squares never exceeds 2^64, so 67 bits hold it exactly
        sq_sum = '0;
        for (int i = 0; i < n; i++) sq_sum += 67'(66'(op.a[i]) * 66'(op.a[i]));
        len = root_floor(sq_sum);
        if (op.func == vaf_pkg::F_LEN) begin
          o.scalar = clamp32($signed({1'b0, len}), sat);
        end else if (len == 0) begin
          for (int i = 0; i < n; i++) o.r[i] = op.a[i];
        end else begin
          for (int i = 0; i < n; i++) begin
            mag = op.a[i] < 0 ? 99'(-68'(op.a[i])) : 99'(op.a[i]);
            q = 68'((mag << FB) / len);
            o.r[i] = clamp32(op.a[i] < 0 ? -q : q, sat);
          end
        end
      end
      default: ;
    endcase
    if (o.status == vaf_pkg::ST_OK && sat) o.status = vaf_pkg::ST_SAT;
    return o;
  endfunction

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      3: return $signed(32'($urandom()) >>> $urandom_range(0, 20));
      default: return $urandom();
    endcase
  endfunction

  function automatic vec_op_t rand_op();
    vec_op_t op;
    op.func = $urandom_range(0, 9) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
    op.dim = $urandom_range(0, 7) == 0 ? 3'($urandom()) : 3'($urandom_range(2, 4));
    for (int i = 0; i < 4; i++) begin
      op.a[i] = rand_comp();
      op.b[i] = rand_comp();
    end
    op.factor = rand_comp();
    return op;
  endfunction

  function automatic vec_op_t mk_op(logic [2:0] f, logic [2:0] d, logic signed [31:0] av,
                                    logic signed [31:0] bv, logic signed [31:0] fv);
    vec_op_t op;
    op.func = f;
    op.dim = d;
    for (int i = 0; i < 4; i++) begin
      op.a[i] = av;
      op.b[i] = bv;
    end
    op.factor = fv;
    return op;
  endfunction

  task automatic send_vec_op(vec_op_t op, bit has_exp, vec_res_t typed);
    vec_res_t p;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op.func;
    s_axis_tdata <= {op.factor, op.b[3], op.b[2], op.b[1], op.b[0],
                     op.a[3], op.a[2], op.a[1], op.a[0], op.dim};
    p = has_exp ? typed : predict_vec_op(op);
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(p);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= !rst && (recv_idle_pct == 0 || $urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    vec_res_t e;
    logic [31:0] got [5];
    bit bad;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready && !rst) begin
      for (int i = 0; i < 5; i++) got[i] = m_axis_tdata[32*i +: 32];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_axis_tdata);
      end else begin
        e = expected_q.pop_front();
        bad = m_axis_tuser != e.status || got[4] != e.scalar;
        for (int i = 0; i < 4; i++) bad |= got[i] != e.r[i];
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r=%h %h %h %h s=%h st=%0d got r=%h %h %h %h s=%h st=%0d",
                     e.r[0], e.r[1], e.r[2], e.r[3], e.scalar, e.status,
                     got[0], got[1], got[2], got[3], got[4], m_axis_tuser);
        end
      end
    end
    if (cycles > MAX_CYCLE) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    vec_res_t z;
    vec_op_t op;
    for (int i = 0; i < 4; i++) z.r[i] = '0;
    z.scalar = '0;
    z.status = vaf_pkg::ST_OK;
    // rows with typed answers: zero vector, cross at dim 4, unused code, saturating add and sub
    row.has_exp = 1;
    row.op = mk_op(vaf_pkg::F_DOT, vaf_pkg::DIM_4, 0, 0, 0);
    row.res = z; rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_NORM, vaf_pkg::DIM_3, 0, 5, 0);
    row.res = z; rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_LEN, vaf_pkg::DIM_2, 0, 0, 0);
    row.res = z; rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_CROSS, vaf_pkg::DIM_4, 32'sh7fffffff, 3, 0);
    row.res = z; row.res.status = vaf_pkg::ST_XDIM; rows.push_back(row);
    row.op = mk_op(3'd7, vaf_pkg::DIM_3, 32'sh10000, 1, 1); row.res = z; rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_ADD, vaf_pkg::DIM_2, 32'sh7fffffff, 32'sh7fffffff, 0);
    row.res = z; row.res.r[0] = 32'h7fffffff; row.res.r[1] = 32'h7fffffff;
    row.res.status = vaf_pkg::ST_SAT; rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_SUB, vaf_pkg::DIM_2, 32'sh80000000, 1, 0);
    row.res = z; row.res.r[0] = 32'h80000000; row.res.r[1] = 32'h80000000;
    row.res.status = vaf_pkg::ST_SAT; rows.push_back(row);
    row.has_exp = 0;
    for (int f = 0; f < 7; f++) begin
      row.op = mk_op(3'(f), 3'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      rows.push_back(row);
      row.op = mk_op(3'(f), 3'd7, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      rows.push_back(row);
    end
    row.op = mk_op(vaf_pkg::F_CROSS, vaf_pkg::DIM_3, 32'sh30000, -32'sh10000, 0);
    row.op.a[1] = 32'sh20000; rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_NORM, vaf_pkg::DIM_4, -32'sh8000, 0, 0); rows.push_back(row);
    row.op = mk_op(vaf_pkg::F_SCALE, vaf_pkg::DIM_3, -32'sh1, 32'sh1, 32'sh18000);
    rows.push_back(row);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_vec_op(rows[i].op, rows[i].has_exp, rows[i].res);
    s_axis_tvalid <= 1'b0;
    // drain completely before the random part
    while (expected_q.size() != 0) @(posedge clk);
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 24;
      end else if (k == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op = rand_op();
      send_vec_op(op, 0, z);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
